// ===== src/fwsr_pkg.sv =====
// Shared types, constants and arithmetic helpers for the four-way spatial RNN sweep
`default_nettype none
package fwsr_pkg;
	localparam int MaxHeightDefault = 64;
	localparam int MaxWidthDefault  = 64;
	localparam int PixW  = 16;
	localparam int OutW  = 15;
	localparam int SumW  = 17;
	localparam int WgtW  = 48;
	localparam logic [WgtW-1:0] WeightReset = 48'h4000_0000_4000;
	localparam logic [6:0] GeomReset = 7'd64;

	localparam logic [5:0] ADDR_HEIGHT = 6'd0;
	localparam logic [5:0] ADDR_WIDTH  = 6'd8;
	localparam logic [5:0] ADDR_W_LR   = 6'd16;
	localparam logic [5:0] ADDR_W_RL   = 6'd24;
	localparam logic [5:0] ADDR_W_TD   = 6'd32;
	localparam logic [5:0] ADDR_W_BU   = 6'd40;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_FETCH = 1'b1
	} op_t;

	typedef struct packed {
		logic             fetch;
		logic [PixW-1:0]  pixel;
	} cmd_t;

	// round Q10.22 product to Q11.8, half up
	function automatic logic signed [18:0] round_q14(input logic signed [31:0] p);
		logic signed [32:0] t;
		t = $signed({p[31], p}) + 33'sd8192;
		return t[32:14];
	endfunction

	function automatic logic [OutW-1:0] relu_sat(input logic signed [19:0] v);
		if (v[19]) return '0;
		if (v > 20'sd32767) return 15'h7fff;
		return v[OutW-1:0];
	endfunction
endpackage
`default_nettype wire

// ===== src/fwsr_stream_if.sv =====
// Valid/ready channel with payload
`default_nettype none
interface fwsr_stream_if #(parameter int W = 17);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== src/fwsr_ram.sv =====
// Generic single-port-write, one-read RAM with registered read
`default_nettype none
module fwsr_ram #(
	parameter int W = 16,
	parameter int D = 4096,
	localparam int AW = (D > 1) ? $clog2(D) : 1
) (
	input  wire logic          clk,
	input  wire logic          we,
	input  wire logic [AW-1:0] waddr,
	input  wire logic [W-1:0]  wdata,
	input  wire logic [AW-1:0] raddr,
	output logic      [W-1:0]  rdata
);
	logic [W-1:0] mem [D];
	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== src/fwsr_front.sv =====
// Input stage: accepts items into a short queue
`default_nettype none
module fwsr_front #(
	parameter int Depth = 2
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire fwsr_pkg::cmd_t in_cmd,
	output logic      q_valid,
	input  wire logic q_pop,
	output fwsr_pkg::cmd_t q_cmd
);
	import fwsr_pkg::*;
	localparam int AW = $clog2(Depth);
	cmd_t buf_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push;
	assign in_ready = cnt_q != Depth[AW:0];
	assign push = in_valid && in_ready;
	assign q_valid = cnt_q != '0;
	assign q_cmd = buf_q[rp_q];
	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= in_cmd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (q_pop) rp_q <= rp_q + 1'b1;
			cnt_q <= cnt_q + {{AW{1'b0}}, push} - {{AW{1'b0}}, q_pop};
		end
	end
endmodule
`default_nettype wire

// ===== src/fwsr_back.sv =====
// Execution engine: plane store, four sweeps, result readout
`default_nettype none
module fwsr_back #(
	parameter int MaxHeight = fwsr_pkg::MaxHeightDefault,
	parameter int MaxWidth  = fwsr_pkg::MaxWidthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output logic      q_pop,
	input  wire fwsr_pkg::cmd_t q_cmd,
	input  wire logic [6:0] height,
	input  wire logic [6:0] width,
	input  wire logic [fwsr_pkg::WgtW-1:0] w_lr,
	input  wire logic [fwsr_pkg::WgtW-1:0] w_rl,
	input  wire logic [fwsr_pkg::WgtW-1:0] w_td,
	input  wire logic [fwsr_pkg::WgtW-1:0] w_bu,
	output logic      out_valid,
	input  wire logic out_ready,
	output logic [fwsr_pkg::OutW-1:0] out_pixel,
	output logic      out_last
);
	import fwsr_pkg::*;
	localparam int Cells = MaxHeight * MaxWidth;
	localparam int AW = (Cells > 1) ? $clog2(Cells) : 1;
	localparam int HW = $clog2(MaxHeight + 1);
	localparam int WW = $clog2(MaxWidth + 1);
	localparam int CW = AW + 1;

	typedef enum logic [2:0] {
		S_IDLE, S_RD, S_MUL1, S_MUL2, S_WR, S_FETCH
	} state_t;
	state_t state_q;

	logic [HW-1:0] eh;
	logic [WW-1:0] ew;
	logic [CW-1:0] count;
	always_comb begin
		if (height == 7'd0) eh = HW'(1);
		else if ({25'd0, height} > MaxHeight) eh = HW'(MaxHeight);
		else eh = HW'(height);
		if (width == 7'd0) ew = WW'(1);
		else if ({25'd0, width} > MaxWidth) ew = WW'(MaxWidth);
		else ew = WW'(width);
		count = CW'(eh) * CW'(ew);
	end

	logic [CW-1:0] load_pos_q, read_pos_q;
	logic ready_q;
	logic [1:0] dir_q;
	logic [HW-1:0] row_q;
	logic [WW-1:0] col_q;
	logic [OutW-1:0] h_q;
	logic signed [31:0] ph_q, px_q;
	logic [AW-1:0] addr_q;
	logic last_step_q;

	logic in_we;
	logic [AW-1:0] in_waddr, in_raddr;
	logic [PixW-1:0] in_rdata;
	logic sum_we;
	logic [AW-1:0] sum_waddr, sum_raddr;
	logic [SumW-1:0] sum_wdata, sum_rdata;

	fwsr_ram #(.W(PixW), .D(Cells)) u_in (
		.clk(clk), .we(in_we), .waddr(in_waddr), .wdata(q_cmd.pixel),
		.raddr(in_raddr), .rdata(in_rdata));
	fwsr_ram #(.W(SumW), .D(Cells)) u_sum (
		.clk(clk), .we(sum_we), .waddr(sum_waddr), .wdata(sum_wdata),
		.raddr(sum_raddr), .rdata(sum_rdata));

	logic [CW-1:0] lpos;
	assign lpos = (load_pos_q < count) ? load_pos_q : count - 1'b1;
	logic [CW-1:0] rpos;
	assign rpos = (read_pos_q < count) ? read_pos_q : count - 1'b1;

	// sweep coordinates: lines are rows for horizontal, columns for vertical
	logic [HW-1:0] r_eff;
	logic [WW-1:0] c_eff;
	always_comb begin
		r_eff = row_q;
		c_eff = col_q;
		case (dir_q)
			2'd1: c_eff = ew - 1'b1 - col_q;
			2'd3: r_eff = eh - 1'b1 - row_q;
			default: ;
		endcase
	end
	logic [AW-1:0] sweep_addr;
	assign sweep_addr = AW'(r_eff) * AW'(ew) + AW'(c_eff);

	logic [WgtW-1:0] wsel;
	always_comb begin
		case (dir_q)
			2'd0: wsel = w_lr;
			2'd1: wsel = w_rl;
			2'd2: wsel = w_td;
			default: wsel = w_bu;
		endcase
	end
	logic signed [15:0] wx, wh, wy;
	assign wx = wsel[15:0];
	assign wh = wsel[31:16];
	assign wy = wsel[47:32];

	logic [OutW-1:0] h_new;
	assign h_new = relu_sat(20'(round_q14(px_q)) + 20'(round_q14(ph_q)));
	logic signed [31:0] py;
	logic [OutW-1:0] y_s2;
	logic signed [31:0] py_s2;
	assign y_s2 = relu_sat(20'(round_q14(py_s2)));

	logic horiz;
	assign horiz = !dir_q[1];
	logic at_line_end, at_last_line;
	assign at_line_end = horiz ? (col_q == ew - 1'b1) : (row_q == eh - 1'b1);
	assign at_last_line = horiz ? (row_q == eh - 1'b1) : (col_q == ew - 1'b1);

	assign in_we = (state_q == S_IDLE) && q_valid && !q_cmd.fetch;
	assign in_waddr = lpos[AW-1:0];
	assign in_raddr = sweep_addr;
	assign sum_raddr = (state_q == S_IDLE) ? rpos[AW-1:0] : sweep_addr;
	assign sum_we = state_q == S_WR;
	assign sum_waddr = addr_q;
	assign sum_wdata = (dir_q == 2'd0) ? SumW'(y_s2) : sum_rdata + SumW'(y_s2);

	logic out_busy;
	assign out_busy = out_valid && !out_ready;
	assign q_pop = (state_q == S_IDLE) && q_valid &&
		(!q_cmd.fetch || !ready_q || !out_busy);
	assign py = $signed({1'b0, h_q}) * wy;

	always_ff @(posedge clk) begin
		ph_q <= $signed({1'b0, h_q}) * wh;
		px_q <= $signed(in_rdata) * wx;
		py_s2 <= py;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			load_pos_q <= '0;
			read_pos_q <= '0;
			ready_q <= 1'b0;
			dir_q <= '0;
			row_q <= '0;
			col_q <= '0;
			h_q <= '0;
			addr_q <= '0;
			last_step_q <= 1'b0;
			out_valid <= 1'b0;
			out_pixel <= '0;
			out_last <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_pop && !q_cmd.fetch) begin
						ready_q <= 1'b0;
						if (load_pos_q + 1'b1 >= count) begin
							load_pos_q <= '0;
							dir_q <= '0;
							row_q <= '0;
							col_q <= '0;
							h_q <= '0;
							state_q <= S_RD;
						end else begin
							load_pos_q <= load_pos_q + 1'b1;
						end
					end else if (q_pop && ready_q) begin
						state_q <= S_FETCH;
					end
				end
				S_FETCH: begin
					out_valid <= 1'b1;
					out_pixel <= sum_rdata[SumW-1:2];
					out_last <= read_pos_q + 1'b1 >= count;
					if (read_pos_q + 1'b1 >= count) begin
						read_pos_q <= '0;
						ready_q <= 1'b0;
					end else begin
						read_pos_q <= read_pos_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_RD: begin
					addr_q <= sweep_addr;
					state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: begin
					h_q <= h_new;
					state_q <= S_WR;
					last_step_q <= 1'b0;
				end
				S_WR: begin
					if (!last_step_q) begin
						// wait for the registered output product
						last_step_q <= 1'b1;
					end else begin
						last_step_q <= 1'b0;
						state_q <= S_RD;
						if (at_line_end) begin
							h_q <= '0;
							if (horiz) col_q <= '0; else row_q <= '0;
							if (at_last_line) begin
								row_q <= '0;
								col_q <= '0;
								dir_q <= dir_q + 1'b1;
								if (dir_q == 2'd3) begin
									state_q <= S_IDLE;
									ready_q <= 1'b1;
									read_pos_q <= '0;
								end
							end else if (horiz) begin
								row_q <= row_q + 1'b1;
							end else begin
								col_q <= col_q + 1'b1;
							end
						end else if (horiz) begin
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== src/four_way_spatial_rnn_sweep_core.sv =====
// Top level: configuration registers, input queue and sweep engine
// Load items are written to the plane store from the idle state; fetch items pass
// through a fetch state. The plane's last load starts four sweeps that visit each pixel
// once per direction, each visit passing through the engine's memory read, two multiply
// stages and a write state that writes twice; results are fetched once the sweeps end.
// A two-entry queue decouples input acceptance from the engine.
`default_nettype none
module four_way_spatial_rnn_sweep_core #(
	parameter int MaxHeight = fwsr_pkg::MaxHeightDefault,
	parameter int MaxWidth  = fwsr_pkg::MaxWidthDefault
) (
	input  wire logic clk,
	input  wire logic arst_n,
	fwsr_stream_if.sink   in_ch,
	fwsr_stream_if.source out_ch,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [5:0]  paddr,
	input  wire logic [63:0] pwdata,
	output logic      [63:0] prdata,
	output logic             pready
);
	import fwsr_pkg::*;
	logic [6:0] height_q, width_q;
	logic [WgtW-1:0] wlr_q, wrl_q, wtd_q, wbu_q;
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= GeomReset;
			width_q <= GeomReset;
			wlr_q <= WeightReset;
			wrl_q <= WeightReset;
			wtd_q <= WeightReset;
			wbu_q <= WeightReset;
		end else if (psel && penable && pwrite) begin
			unique case (paddr)
				ADDR_HEIGHT: height_q <= pwdata[6:0];
				ADDR_WIDTH:  width_q <= pwdata[6:0];
				ADDR_W_LR:   wlr_q <= pwdata[WgtW-1:0];
				ADDR_W_RL:   wrl_q <= pwdata[WgtW-1:0];
				ADDR_W_TD:   wtd_q <= pwdata[WgtW-1:0];
				ADDR_W_BU:   wbu_q <= pwdata[WgtW-1:0];
				default: ;
			endcase
		end
	end
	always_comb begin
		unique case (paddr)
			ADDR_HEIGHT: prdata = {57'd0, height_q};
			ADDR_WIDTH:  prdata = {57'd0, width_q};
			ADDR_W_LR:   prdata = {16'd0, wlr_q};
			ADDR_W_RL:   prdata = {16'd0, wrl_q};
			ADDR_W_TD:   prdata = {16'd0, wtd_q};
			ADDR_W_BU:   prdata = {16'd0, wbu_q};
			default:     prdata = '0;
		endcase
	end

	cmd_t in_cmd, q_cmd;
	logic q_valid, q_pop;
	assign in_cmd = in_ch.data;
	fwsr_front #(.Depth(2)) u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.in_cmd(in_cmd), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd));

	logic [OutW-1:0] opix;
	logic olast;
	fwsr_back #(.MaxHeight(MaxHeight), .MaxWidth(MaxWidth)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_pop(q_pop), .q_cmd(q_cmd),
		.height(height_q), .width(width_q), .w_lr(wlr_q), .w_rl(wrl_q),
		.w_td(wtd_q), .w_bu(wbu_q), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_pixel(opix), .out_last(olast));
	assign out_ch.data = {opix, olast};
endmodule
`default_nettype wire

// ===== src/fwsr_checker.sv =====
// Port-level checker for the sweep core, bound to the top level
`default_nettype none
module fwsr_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	input wire logic in_ready,
	input wire logic out_valid,
	input wire logic out_ready,
	input wire logic [15:0] out_data,
	input wire logic pready
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result dropped while stalled");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");
	a_out_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_data[15:1] <= 15'h7fff)
		else $error("result out of range");
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid |-> !$isunknown(in_ready))
		else $error("input ready unknown");
endmodule
bind four_way_spatial_rnn_sweep_core fwsr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
	.pready(pready));
`default_nettype wire
